>>> rtl/bcd_clock_alarm_timer_stopwatch_assert.svh
// Assertion macros shared by the clock, alarm, countdown and stopwatch RTL.
`ifndef BCD_CLOCK_ALARM_TIMER_STOPWATCH_ASSERT_SVH
`define BCD_CLOCK_ALARM_TIMER_STOPWATCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcat: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BCAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcat: next-cycle check failed");

`endif

>>> rtl/bcat_pkg.sv
package bcat_pkg;

  // Digit positions of one time value.
  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned SHOWN_W    = 23;
  localparam int unsigned PRESCALE_W = 8;

  // BCD counting limits.
  localparam logic [3:0] BCD_TEN         = 4'd10;
  localparam logic [3:0] TENS_BASE       = 4'd6;
  localparam logic [3:0] UNITS_MAX       = 4'd9;
  localparam logic [3:0] TENS_MAX        = 4'd5;
  localparam logic [3:0] HOUR_TENS_WRAP  = 4'd2;
  localparam logic [3:0] HOUR_UNITS_WRAP = 4'd4;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd60;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [NUM_DIGITS-1:0] bcd_time_t;

  // Clock value after reset: 23:01:00.
  localparam bcd_time_t CLOCK_RESET = {4'd2, 4'd3, 4'd0, 4'd1, 4'd0, 4'd0};

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_SET_ALARM     = 3'd1,
    OP_SET_COUNTDOWN = 3'd2,
    OP_TOGGLE_CD     = 3'd3,
    OP_TOGGLE_SW     = 3'd4,
    OP_CLEAR_SW      = 3'd5,
    OP_ALARM_ACK     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    VIEW_CLOCK     = 2'd0,
    VIEW_ALARM     = 2'd1,
    VIEW_COUNTDOWN = 2'd2,
    VIEW_STOPWATCH = 2'd3
  } view_t;

  // One input item.
  typedef struct packed {
    logic [2:0] op;
    view_t      view;
    logic [2:0] digit_index;
    logic [3:0] digit_value;
    logic       buttons_released;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [SHOWN_W-1:0] shown_time;
    logic               alarm_ringing;
    logic               countdown_at_zero;
    logic               countdown_running;
    logic               stopwatch_running;
  } result_t;

  function automatic logic all_zero(bcd_time_t d);
    return (d == '0);
  endfunction

  // One-second increment with a 24-hour wrap.
  function automatic bcd_time_t count_up(bcd_time_t d);
    bcd_time_t r;
    r = d;
    r[0] = r[0] + 4'd1;
    if (r[0] >= BCD_TEN) begin
      r[0] = '0;
      r[1] = r[1] + 4'd1;
    end
    if (r[1] >= TENS_BASE) begin
      r[1] = '0;
      r[2] = r[2] + 4'd1;
    end
    if (r[2] >= BCD_TEN) begin
      r[2] = '0;
      r[3] = r[3] + 4'd1;
    end
    if (r[3] >= TENS_BASE) begin
      r[3] = '0;
      r[4] = r[4] + 4'd1;
    end
    if (r[4] >= BCD_TEN) begin
      r[4] = '0;
      r[5] = r[5] + 4'd1;
    end
    if (r[5] >= HOUR_TENS_WRAP && r[4] >= HOUR_UNITS_WRAP) begin
      r[5] = '0;
      r[4] = '0;
    end
    return r;
  endfunction

  // One-second decrement; a zero digit below the first nonzero one
  // reloads to its top value (nine for units, five for tens).
  function automatic bcd_time_t count_down(bcd_time_t d);
    bcd_time_t r;
    logic      borrow;
    r      = d;
    borrow = 1'b1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (borrow) begin
        if (d[k] != '0) begin
          r[k]   = d[k] - 4'd1;
          borrow = 1'b0;
        end else begin
          r[k] = (k % 2 == 1) ? TENS_MAX : UNITS_MAX;
        end
      end
    end
    return r;
  endfunction

  // Write one digit with clamping; positions above five leave d unchanged.
  function automatic bcd_time_t set_digit(bcd_time_t d, logic [2:0] idx, logic [3:0] val);
    bcd_time_t r;
    bcd_t      lim;
    r   = d;
    lim = idx[0] ? TENS_MAX : UNITS_MAX;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (idx == 3'(k)) begin
        r[k] = (val > lim) ? lim : val;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/bcat_core.sv
module bcat_core
  import bcat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [PRESCALE_W-1:0] cfg_wdata,
  input  logic                  fire,
  input  item_t                 item,
  output result_t               res
);

  `include "bcd_clock_alarm_timer_stopwatch_assert.svh"

  logic [PRESCALE_W-1:0] prescale_r;
  logic [PRESCALE_W-1:0] pcount_r, pcount_nxt;
  bcd_time_t             clock_r, clock_nxt;
  bcd_time_t             alarm_r, alarm_nxt;
  bcd_time_t             cdown_r, cdown_nxt;
  bcd_time_t             swatch_r, swatch_nxt;
  logic                  cd_on_r, cd_on_nxt;
  logic                  sw_on_r, sw_on_nxt;
  logic                  alarm_flag_r, alarm_flag_nxt;
  bcd_time_t             shown;

  // Event decode and next state for the item in the input register.
  always_comb begin
    pcount_nxt     = pcount_r;
    clock_nxt      = clock_r;
    alarm_nxt      = alarm_r;
    cdown_nxt      = cdown_r;
    swatch_nxt     = swatch_r;
    cd_on_nxt      = cd_on_r;
    sw_on_nxt      = sw_on_r;
    alarm_flag_nxt = alarm_flag_r;
    unique case (item.op)
      OP_TICK: begin
        // The countdown counts only with its view up and the buttons released.
        if (cd_on_r && item.view == VIEW_COUNTDOWN && item.buttons_released) begin
          if (all_zero(cdown_r)) begin
            cd_on_nxt = 1'b0;
          end else begin
            cdown_nxt = count_down(cdown_r);
            if (all_zero(cdown_nxt)) begin
              cd_on_nxt = 1'b0;
            end
          end
        end
        if (sw_on_r && item.view == VIEW_STOPWATCH) begin
          swatch_nxt = count_up(swatch_r);
        end
        // The clock advances once per prescale period.
        if ({1'b0, pcount_r} + 9'd1 >= {1'b0, prescale_r}) begin
          pcount_nxt = '0;
          clock_nxt  = count_up(clock_r);
        end else begin
          pcount_nxt = pcount_r + 8'd1;
        end
        if (clock_nxt == alarm_r) begin
          alarm_flag_nxt = 1'b1;
        end
      end
      OP_SET_ALARM: begin
        alarm_nxt = set_digit(alarm_r, item.digit_index, item.digit_value);
      end
      OP_SET_COUNTDOWN: begin
        if (!cd_on_r) begin
          cdown_nxt = set_digit(cdown_r, item.digit_index, item.digit_value);
        end
      end
      OP_TOGGLE_CD: begin
        if (!all_zero(cdown_r)) begin
          cd_on_nxt = !cd_on_r;
        end
      end
      OP_TOGGLE_SW: begin
        sw_on_nxt = !sw_on_r;
      end
      OP_CLEAR_SW: begin
        swatch_nxt = '0;
      end
      OP_ALARM_ACK: begin
        alarm_flag_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // The result reflects the state after this item.
  always_comb begin
    unique case (item.view)
      VIEW_CLOCK:     shown = clock_nxt;
      VIEW_ALARM:     shown = alarm_nxt;
      VIEW_COUNTDOWN: shown = cdown_nxt;
      VIEW_STOPWATCH: shown = swatch_nxt;
      default:        shown = swatch_nxt;
    endcase
    res.shown_time        = SHOWN_W'(shown);
    res.alarm_ringing     = alarm_flag_nxt;
    res.countdown_at_zero = all_zero(cdown_nxt);
    res.countdown_running = cd_on_nxt;
    res.stopwatch_running = sw_on_nxt;
  end

  // Prescale register: user writes only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RESET;
    end else if (cfg_we) begin
      prescale_r <= cfg_wdata;
    end
  end

  // State registers update once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r     <= '0;
      clock_r      <= CLOCK_RESET;
      alarm_r      <= '0;
      cdown_r      <= '0;
      swatch_r     <= '0;
      cd_on_r      <= 1'b0;
      sw_on_r      <= 1'b0;
      alarm_flag_r <= 1'b0;
    end else if (fire) begin
      pcount_r     <= pcount_nxt;
      clock_r      <= clock_nxt;
      alarm_r      <= alarm_nxt;
      cdown_r      <= cdown_nxt;
      swatch_r     <= swatch_nxt;
      cd_on_r      <= cd_on_nxt;
      sw_on_r      <= sw_on_nxt;
      alarm_flag_r <= alarm_flag_nxt;
    end
  end

  // A running countdown always has time left on it.
  `BCAT_ASSERT_NOW(a_cd_running_nonzero, cd_on_r, !all_zero(cdown_r))
  // The alarm flag rises only through a tick.
  `BCAT_ASSERT_NOW(a_alarm_from_tick, $rose(alarm_flag_r), $past(fire && item.op == OP_TICK))
  // The stopwatch holds its value between items.
  `BCAT_ASSERT_NEXT(a_sw_holds, !fire, $stable(swatch_r))
  // The clock never shows an hour past 23.
  `BCAT_ASSERT_NOW(a_clock_hours, clock_r[5] == HOUR_TENS_WRAP, clock_r[4] < HOUR_UNITS_WRAP)

endmodule

>>> rtl/bcd_clock_alarm_timer_stopwatch.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------------
// input     | in_valid, in_stall  | in_op, in_view, in_digit_index, in_digit_value,
//           |                     | in_buttons_released
// result    | out_valid, out_stall| out_shown_time, out_alarm_ringing,
//           |                     | out_countdown_at_zero, out_countdown_running,
//           |                     | out_stopwatch_running
// config    | cfg_we              | cfg_wdata (clock prescale)
//
// One item per cycle while out_stall is low.
// The input register feeds one pass of BCD update logic into the result register.
// A held result stalls a full input register; in_stall follows out_stall in that cycle.
// Synchronous active-low reset: clock 23:01:00, prescale 60, other state zero.
module bcd_clock_alarm_timer_stopwatch
  import bcat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [PRESCALE_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  logic [1:0]            in_view,
  input  logic [2:0]            in_digit_index,
  input  logic [3:0]            in_digit_value,
  input  logic                  in_buttons_released,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SHOWN_W-1:0]    out_shown_time,
  output logic                  out_alarm_ringing,
  output logic                  out_countdown_at_zero,
  output logic                  out_countdown_running,
  output logic                  out_stopwatch_running
);

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  logic    res_load;
  logic    fire;

  // The result register takes a new item when it is empty or being drained.
  assign res_load = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && res_load;
  assign in_stall = in_valid_r && !res_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.op               <= in_op;
      item_r.view             <= view_t'(in_view);
      item_r.digit_index      <= in_digit_index;
      item_r.digit_value      <= in_digit_value;
      item_r.buttons_released <= in_buttons_released;
    end
  end

  bcat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item_r),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_shown_time        = res_r.shown_time;
  assign out_alarm_ringing     = res_r.alarm_ringing;
  assign out_countdown_at_zero = res_r.countdown_at_zero;
  assign out_countdown_running = res_r.countdown_running;
  assign out_stopwatch_running = res_r.stopwatch_running;

endmodule

>>> verif/tb_bcd_clock_alarm_timer_stopwatch.sv
module tb_bcd_clock_alarm_timer_stopwatch;
  timeunit 1ns;
  timeprecision 1ps;

  import bcat_pkg::*;

  localparam int unsigned DAY_SECS      = 86400;
  localparam int unsigned CYCLE_LIMIT   = 60000;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SHAPED_TARGET = 1650;
  localparam int unsigned NUM_PHASES    = 9;

  // Op code that the block does not decode.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Mixed radix of the six digits, seconds units first.
  localparam int unsigned DIGIT_RADIX [NUM_DIGITS] = '{10, 6, 10, 6, 10, 6};

  // Prescale settings of the random phases; 255 right before 3 lowers the register
  // while the prescale count is high.
  localparam logic [PRESCALE_W-1:0] PHASE_PRESCALE [NUM_PHASES] =
    '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd60, 8'd4, 8'd255, 8'd3};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [PRESCALE_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_op               = '0;
  logic [1:0]            in_view             = '0;
  logic [2:0]            in_digit_index      = '0;
  logic [3:0]            in_digit_value      = '0;
  logic                  in_buttons_released = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SHOWN_W-1:0]    out_shown_time;
  logic                  out_alarm_ringing;
  logic                  out_countdown_at_zero;
  logic                  out_countdown_running;
  logic                  out_stopwatch_running;

  bcd_clock_alarm_timer_stopwatch dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_view               (in_view),
    .in_digit_index        (in_digit_index),
    .in_digit_value        (in_digit_value),
    .in_buttons_released   (in_buttons_released),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_shown_time        (out_shown_time),
    .out_alarm_ringing     (out_alarm_ringing),
    .out_countdown_at_zero (out_countdown_at_zero),
    .out_countdown_running (out_countdown_running),
    .out_stopwatch_running (out_stopwatch_running)
  );

  // Items waiting to be offered, and the status each accepted item should produce.
  item_t       pending_items[$];
  result_t     status_due[$];
  item_t       offered;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned shaped_items = 0;
  bit          idle_en      = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;

  // Shadow of the block's times, prescaler and flags.
  bcd_time_t             clock_now;
  bcd_time_t             alarm_set;
  bcd_time_t             cd_time;
  bcd_time_t             sw_time;
  logic [PRESCALE_W-1:0] presc_reg;
  logic [PRESCALE_W-1:0] presc_cnt;
  logic                  cd_on;
  logic                  sw_on;
  logic                  ringing;

  initial begin
    forever #5 clk = ~clk;
  end

  // Digits as a mixed-radix number of seconds; exact for every clamped digit set.
  function automatic int unsigned to_secs(bcd_time_t d);
    int unsigned s;
    s = 0;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      s = s * DIGIT_RADIX[k] + d[k];
    end
    return s;
  endfunction

  function automatic bcd_time_t from_secs(int unsigned s);
    bcd_time_t d;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      d[k] = 4'(s % DIGIT_RADIX[k]);
      s    = s / DIGIT_RADIX[k];
    end
    return d;
  endfunction

  // Digit write with tens clamped to five and units to nine.
  function automatic bcd_time_t with_digit(bcd_time_t d, logic [2:0] pos, logic [3:0] val);
    logic [3:0] top;
    top = pos[0] ? TENS_MAX : UNITS_MAX;
    if (pos < 3'(NUM_DIGITS)) d[pos] = (val > top) ? top : val;
    return d;
  endfunction

  function automatic item_t mk(logic [2:0] op, logic [1:0] view, logic [2:0] pos,
                               logic [3:0] val, logic rel);
    item_t it;
    it.op               = op;
    it.view             = view_t'(view);
    it.digit_index      = pos;
    it.digit_value      = val;
    it.buttons_released = rel;
    return it;
  endfunction

  task automatic push(item_t it, bit shaped = 1'b1);
    pending_items.push_back(it);
    if (shaped) shaped_items++;
  endtask

  // Apply one event to the shadow state and queue the status it produces.
  task automatic apply_event(item_t it);
    result_t   r;
    bcd_time_t shown;
    case (it.op)
      OP_TICK: begin
        if (cd_on && it.view == VIEW_COUNTDOWN && it.buttons_released) begin
          if (cd_time != '0) cd_time = from_secs(to_secs(cd_time) - 1);
          if (cd_time == '0) cd_on = 1'b0;
        end
        if (sw_on && it.view == VIEW_STOPWATCH) begin
          sw_time = from_secs((to_secs(sw_time) + 1) % DAY_SECS);
        end
        if (int'(presc_cnt) + 1 >= int'(presc_reg)) begin
          presc_cnt = '0;
          clock_now = from_secs((to_secs(clock_now) + 1) % DAY_SECS);
        end else begin
          presc_cnt = presc_cnt + 1'b1;
        end
        if (clock_now == alarm_set) ringing = 1'b1;
      end
      OP_SET_ALARM:     alarm_set = with_digit(alarm_set, it.digit_index, it.digit_value);
      OP_SET_COUNTDOWN: if (!cd_on) cd_time = with_digit(cd_time, it.digit_index, it.digit_value);
      OP_TOGGLE_CD:     if (cd_time != '0) cd_on = !cd_on;
      OP_TOGGLE_SW:     sw_on = !sw_on;
      OP_CLEAR_SW:      sw_time = '0;
      OP_ALARM_ACK:     ringing = 1'b0;
      default: ;
    endcase
    case (it.view)
      VIEW_CLOCK:     shown = clock_now;
      VIEW_ALARM:     shown = alarm_set;
      VIEW_COUNTDOWN: shown = cd_time;
      default:        shown = sw_time;
    endcase
    r.shown_time        = SHOWN_W'(shown);
    r.alarm_ringing     = ringing;
    r.countdown_at_zero = (cd_time == '0);
    r.countdown_running = cd_on;
    r.stopwatch_running = sw_on;
    status_due.push_back(r);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Wait until no item is queued, offered or owed a result.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic write_prescale(logic [PRESCALE_W-1:0] v);
    wait_idle();
    repeat (3) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    presc_reg = v;
    @(negedge clk);
  endtask

  // Input driver: offer queued items, hold each until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_event(offered);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
          offered = pending_items.pop_front();
          in_valid            <= 1'b1;
          in_op               <= offered.op;
          in_view             <= offered.view;
          in_digit_index      <= offered.digit_index;
          in_digit_value      <= offered.digit_value;
          in_buttons_released <= offered.buttons_released;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: random, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result monitor: compare each taken result with the oldest owed status.
  always @(posedge clk) begin : result_mon
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $display("%0t: result with nothing expected: shown 0x%0h", $time, out_shown_time);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("shown_time", want.shown_time, out_shown_time);
        check_field("alarm_ringing", want.alarm_ringing, out_alarm_ringing);
        check_field("countdown_at_zero", want.countdown_at_zero, out_countdown_at_zero);
        check_field("countdown_running", want.countdown_running, out_countdown_running);
        check_field("stopwatch_running", want.stopwatch_running, out_stopwatch_running);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned k;
    int unsigned s;
    int unsigned ticks;
    int unsigned phase_end;
    int unsigned step;
    bcd_time_t   target;

    clock_now = from_secs(23 * 3600 + 60);
    alarm_set = '0;
    cd_time   = '0;
    sw_time   = '0;
    presc_reg = PRESCALE_RESET;
    presc_cnt = '0;
    cd_on     = 1'b0;
    sw_on     = 1'b0;
    ringing   = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clamps, ignored writes, alarm match and re-match, countdown borrow
    // into the hours units, gated countdown ticks, stopwatch controls.
    push(mk(OP_UNUSED, VIEW_CLOCK, 0, 0, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 0, 15, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 1, 15, 0));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 6, 9, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 0, 0, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 1, 0, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 2, 1, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 4, 3, 1));
    push(mk(OP_SET_ALARM, VIEW_ALARM, 5, 2, 1));
    push(mk(OP_TICK, VIEW_ALARM, 7, 15, 1));
    push(mk(OP_ALARM_ACK, VIEW_CLOCK, 0, 0, 1));
    push(mk(OP_TICK, VIEW_CLOCK, 0, 0, 1));
    push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
    push(mk(OP_SET_COUNTDOWN, VIEW_COUNTDOWN, 5, 1, 1));
    push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
    push(mk(OP_SET_COUNTDOWN, VIEW_COUNTDOWN, 0, 7, 1));
    push(mk(OP_TICK, VIEW_COUNTDOWN, 0, 0, 1));
    push(mk(OP_TICK, VIEW_COUNTDOWN, 0, 0, 0));
    push(mk(OP_TICK, VIEW_ALARM, 0, 0, 1));
    push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
    push(mk(OP_TOGGLE_SW, VIEW_STOPWATCH, 0, 0, 1));
    push(mk(OP_TICK, VIEW_STOPWATCH, 0, 0, 0));
    push(mk(OP_TICK, VIEW_STOPWATCH, 0, 0, 1));
    push(mk(OP_CLEAR_SW, VIEW_STOPWATCH, 0, 0, 1));
    push(mk(OP_TOGGLE_SW, VIEW_STOPWATCH, 0, 0, 1));

    // Random phases, each under its own prescale setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_prescale(PHASE_PRESCALE[ph]);
      idle_en   = (ph != 4);
      phase_end = shaped_items + SHAPED_TARGET / NUM_PHASES;
      if (ph == 2) begin
        for (n = 0; n < 30; n++) push(mk(OP_TICK, $urandom_range(0, 3), 0, 0, 1));
        hold_req = 1'b1;
      end
      while (shaped_items < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // Alarm chase: set the alarm 0 to 6 seconds past the clock and tick up to it.
            wait_idle();
            step = (presc_reg == 0) ? 1 : presc_reg;
            if (presc_reg <= 4) begin
              k     = $urandom_range(1, 6);
              ticks = (k + 1) * step + 2;
            end else begin
              k     = 0;
              ticks = $urandom_range(2, 6);
            end
            target = from_secs((to_secs(clock_now) + k) % DAY_SECS);
            for (n = 0; n < NUM_DIGITS; n++) begin
              push(mk(OP_SET_ALARM, $urandom_range(0, 3), n, target[n], $urandom_range(0, 1)));
            end
            for (n = 0; n < ticks; n++) begin
              push(mk(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 7),
                      $urandom_range(0, 15), $urandom_range(0, 1)));
            end
            push(mk(OP_ALARM_ACK, $urandom_range(0, 3), 0, 0, 1));
            push(mk(OP_TICK, VIEW_CLOCK, 0, 0, 1));
            push(mk(OP_TICK, VIEW_ALARM, 0, 0, 0));
            if ($urandom_range(0, 1)) push(mk(OP_ALARM_ACK, VIEW_CLOCK, 0, 0, 1));
          end
          2, 3: begin
            // Countdown run: load a time, start it and tick it down.
            wait_idle();
            if (cd_on) push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
            case ($urandom_range(0, 2))
              0:       s = $urandom_range(1, 12);
              1:       s = $urandom_range(1, 3) * 60 + $urandom_range(0, 4);
              default: s = ($urandom_range(0, 1) ? $urandom_range(1, 5) * 10
                                                 : $urandom_range(1, 59)) * 3600
                           + $urandom_range(0, 3);
            endcase
            target = from_secs(s);
            for (n = 0; n < NUM_DIGITS; n++) begin
              push(mk(OP_SET_COUNTDOWN, $urandom_range(0, 3), n, target[n],
                      $urandom_range(0, 1)));
            end
            push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
            ticks = s % 60 + $urandom_range(2, 5);
            for (n = 0; n < ticks; n++) begin
              push(mk(OP_TICK,
                      ($urandom_range(99) < 85) ? 2'(VIEW_COUNTDOWN) : 2'($urandom_range(0, 3)),
                      $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(99) < 85));
            end
            if ($urandom_range(0, 1)) push(mk(OP_TOGGLE_CD, VIEW_COUNTDOWN, 0, 0, 1));
          end
          4, 5: begin
            // Stopwatch run: make sure it is running and tick it across minute boundaries.
            wait_idle();
            if (!sw_on) push(mk(OP_TOGGLE_SW, VIEW_STOPWATCH, 0, 0, 1));
            if ($urandom_range(0, 3) == 0) push(mk(OP_CLEAR_SW, VIEW_STOPWATCH, 0, 0, 1));
            ticks = $urandom_range(5, 90);
            for (n = 0; n < ticks; n++) begin
              push(mk(OP_TICK,
                      ($urandom_range(99) < 85) ? 2'(VIEW_STOPWATCH) : 2'($urandom_range(0, 3)),
                      $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1)));
              if ($urandom_range(99) == 0) push(mk(OP_CLEAR_SW, $urandom_range(0, 3), 0, 0, 1));
            end
            if ($urandom_range(0, 1)) push(mk(OP_TOGGLE_SW, VIEW_STOPWATCH, 0, 0, 1));
          end
          6, 7: begin
            // Plain ticks under random views and buttons.
            ticks = $urandom_range(5, 25);
            for (n = 0; n < ticks; n++) begin
              push(mk(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 7),
                      $urandom_range(0, 15), $urandom_range(0, 1)));
            end
          end
          8: begin
            // Control sweep: digit writes with out-of-range values, toggles, clears, acks.
            ticks = $urandom_range(4, 12);
            for (n = 0; n < ticks; n++) begin
              push(mk($urandom_range(OP_SET_ALARM, OP_ALARM_ACK), $urandom_range(0, 3),
                      $urandom_range(0, 5), $urandom_range(0, 15), $urandom_range(0, 1)));
            end
          end
          default: begin
            // Noise: any field value, the unused op and out-of-range positions included.
            ticks = $urandom_range(5, 15);
            for (n = 0; n < ticks; n++) begin
              push(mk($urandom_range(0, OP_UNUSED), $urandom_range(0, 3), $urandom_range(0, 7),
                      $urandom_range(0, 15), $urandom_range(0, 1)), 1'b0);
            end
          end
        endcase
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bcd_clock_alarm_timer_stopwatch.f
+incdir+rtl
rtl/bcat_pkg.sv
rtl/bcat_core.sv
rtl/bcd_clock_alarm_timer_stopwatch.sv
verif/tb_bcd_clock_alarm_timer_stopwatch.sv
